// ===== rtl/dps_pkg.sv =====
// Shared types and codes of the deadline scheduler.
package dps_pkg;

  localparam int IdW   = 7;
  localparam int TimeW = 32;
  localparam int WorkW = 16;

  localparam logic CmdArrive = 1'b0;
  localparam logic CmdTick   = 1'b1;

  typedef enum logic [1:0] {
    EvEntered  = 2'd0,
    EvRunning  = 2'd1,
    EvFinished = 2'd2,
    EvBusy     = 2'd3
  } event_e;

  typedef struct packed {
    logic             busy;
    logic [TimeW-1:0] stamp;
    logic [WorkW-1:0] needed;
    logic [WorkW-1:0] left;
    logic [WorkW-1:0] due;
  } rec_t;

  typedef struct packed {
    event_e           ev;
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] tat;
    logic [TimeW-1:0] wt;
    logic             met;
    logic             last;
  } res_t;

endpackage

// ===== rtl/dps_table.sv =====
// Task table memory: one write port, one registered read port.
module dps_table import dps_pkg::*; #(
  parameter int TASKS = 128,
  parameter int AW    = $clog2(TASKS)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  rec_t          wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output rec_t          rd_data_o
);

  rec_t mem_q [TASKS];
  rec_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/dps_seq.sv =====
// Event sequencer: table read-modify-write, deadline scan and result ordering.
module dps_seq import dps_pkg::*; #(
  parameter int TASKS = 128,
  parameter int AW    = $clog2(TASKS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             cmd_i,
  input  logic [IdW-1:0]   task_req_i,
  input  logic [WorkW-1:0] service_time_i,
  input  logic [WorkW-1:0] deadline_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o,
  output logic             wr_en_o,
  output logic [AW-1:0]    wr_addr_o,
  output rec_t             wr_data_o,
  output logic             rd_en_o,
  output logic [AW-1:0]    rd_addr_o,
  input  rec_t             rd_data_i
);

  localparam logic [2:0] StClr      = 3'd0;
  localparam logic [2:0] StIdle     = 3'd1;
  localparam logic [2:0] StAchk     = 3'd2;
  localparam logic [2:0] StTchk     = 3'd3;
  localparam logic [2:0] StScan     = 3'd4;
  localparam logic [2:0] StScanLast = 3'd5;
  localparam logic [2:0] StEmitA    = 3'd6;
  localparam logic [2:0] StEmitB    = 3'd7;

  localparam logic [AW-1:0] LastSlot = AW'(TASKS - 1);

  logic [2:0]       state_q, state_d;
  logic [AW-1:0]    scan_q, scan_d;
  logic [TimeW-1:0] clock_q, clock_d;
  logic             has_cur_q, has_cur_d;
  logic [AW-1:0]    cur_slot_q, cur_slot_d;
  logic [WorkW-1:0] cur_due_q, cur_due_d;
  logic             found_q, found_d;
  logic [AW-1:0]    best_q, best_d;
  logic [WorkW-1:0] best_due_q, best_due_d;
  logic [AW-1:0]    slot_q, slot_d;
  logic [WorkW-1:0] svc_q, svc_d;
  logic [WorkW-1:0] dl_q, dl_d;
  event_e           ev_a_q, ev_a_d;
  logic [IdW-1:0]   id_a_q, id_a_d;
  logic [TimeW-1:0] tat_q, tat_d;
  logic [TimeW-1:0] wt_q, wt_d;
  logic             met_q, met_d;
  logic             has_b_q, has_b_d;
  logic [AW-1:0]    id_b_q, id_b_d;

  logic             accept;
  logic             slot_out;
  logic [WorkW-1:0] left_dec;
  logic [TimeW-1:0] tat_c;
  logic [AW-1:0]    cmp_idx;
  logic             cand;
  logic             found_c;
  logic [AW-1:0]    best_c;
  logic [WorkW-1:0] best_due_c;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);
  assign slot_out   = (32'(task_req_i) >= 32'(TASKS));
  assign left_dec   = rd_data_i.left - WorkW'(1);
  assign tat_c      = clock_q - rd_data_i.stamp;

  assign cmp_idx    = (state_q == StScanLast) ? LastSlot : scan_q - AW'(1);
  assign cand       = rd_data_i.busy && (!found_q || (rd_data_i.due < best_due_q));
  assign found_c    = found_q || cand;
  assign best_c     = cand ? cmp_idx : best_q;
  assign best_due_c = cand ? rd_data_i.due : best_due_q;

  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    clock_d    = clock_q;
    has_cur_d  = has_cur_q;
    cur_slot_d = cur_slot_q;
    cur_due_d  = cur_due_q;
    found_d    = found_q;
    best_d     = best_q;
    best_due_d = best_due_q;
    slot_d     = slot_q;
    svc_d      = svc_q;
    dl_d       = dl_q;
    ev_a_d     = ev_a_q;
    id_a_d     = id_a_q;
    tat_d      = tat_q;
    wt_d       = wt_q;
    met_d      = met_q;
    has_b_d    = has_b_q;
    id_b_d     = id_b_q;
    wr_en_o    = 1'b0;
    wr_addr_o  = slot_q;
    wr_data_o  = rd_data_i;
    rd_en_o    = 1'b0;
    rd_addr_o  = scan_q;
    res_valid_o = 1'b0;
    res_o.ev   = ev_a_q;
    res_o.id   = id_a_q;
    res_o.now  = clock_q;
    res_o.tat  = tat_q;
    res_o.wt   = wt_q;
    res_o.met  = met_q;
    res_o.last = !has_b_q;

    unique case (state_q)
      StClr: begin
        wr_en_o        = 1'b1;
        wr_addr_o      = scan_q;
        wr_data_o      = '0;
        if (scan_q == LastSlot) begin
          state_d = StIdle;
        end else begin
          scan_d = scan_q + AW'(1);
        end
      end
      StIdle: begin
        if (accept) begin
          if (cmd_i == CmdArrive) begin
            slot_d  = AW'(task_req_i);
            svc_d   = (service_time_i == '0) ? WorkW'(1) : service_time_i;
            dl_d    = deadline_i;
            id_a_d  = task_req_i;
            tat_d   = '0;
            wt_d    = '0;
            met_d   = 1'b0;
            has_b_d = 1'b0;
            if (slot_out) begin
              ev_a_d  = EvBusy;
              state_d = StEmitA;
            end else begin
              rd_en_o   = 1'b1;
              rd_addr_o = AW'(task_req_i);
              state_d   = StAchk;
            end
          end else begin
            clock_d = clock_q + TimeW'(1);
            if (has_cur_q) begin
              rd_en_o   = 1'b1;
              rd_addr_o = cur_slot_q;
              slot_d    = cur_slot_q;
              state_d   = StTchk;
            end
          end
        end
      end
      StAchk: begin
        if (rd_data_i.busy) begin
          ev_a_d = EvBusy;
        end else begin
          wr_en_o          = 1'b1;
          wr_data_o.busy   = 1'b1;
          wr_data_o.stamp  = clock_q;
          wr_data_o.needed = svc_q;
          wr_data_o.left   = svc_q;
          wr_data_o.due    = dl_q;
          ev_a_d           = EvEntered;
          if (!has_cur_q || (dl_q < cur_due_q)) begin
            has_b_d    = 1'b1;
            id_b_d     = slot_q;
            has_cur_d  = 1'b1;
            cur_slot_d = slot_q;
            cur_due_d  = dl_q;
          end
        end
        state_d = StEmitA;
      end
      StTchk: begin
        wr_en_o        = 1'b1;
        wr_data_o.left = left_dec;
        if (left_dec != '0) begin
          state_d = StIdle;
        end else begin
          wr_data_o.busy = 1'b0;
          ev_a_d    = EvFinished;
          id_a_d    = IdW'(slot_q);
          tat_d     = tat_c;
          wt_d      = tat_c - TimeW'(rd_data_i.needed);
          met_d     = (tat_c <= TimeW'(rd_data_i.due));
          has_b_d   = 1'b0;
          has_cur_d = 1'b0;
          found_d   = 1'b0;
          scan_d    = '0;
          state_d   = StScan;
        end
      end
      StScan: begin
        rd_en_o = 1'b1;
        if (scan_q != '0) begin
          found_d    = found_c;
          best_d     = best_c;
          best_due_d = best_due_c;
        end
        if (scan_q == LastSlot) begin
          state_d = StScanLast;
        end else begin
          scan_d = scan_q + AW'(1);
        end
      end
      StScanLast: begin
        if (found_c) begin
          has_b_d    = 1'b1;
          id_b_d     = best_c;
          has_cur_d  = 1'b1;
          cur_slot_d = best_c;
          cur_due_d  = best_due_c;
        end
        state_d = StEmitA;
      end
      StEmitA: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = has_b_q ? StEmitB : StIdle;
        end
      end
      StEmitB: begin
        res_valid_o = 1'b1;
        res_o.ev    = EvRunning;
        res_o.id    = IdW'(id_b_q);
        res_o.tat   = '0;
        res_o.wt    = '0;
        res_o.met   = 1'b0;
        res_o.last  = 1'b1;
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClr;
      scan_q    <= '0;
      clock_q   <= '0;
      has_cur_q <= 1'b0;
      cur_slot_q <= '0;
      found_q   <= 1'b0;
      has_b_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      scan_q    <= scan_d;
      clock_q   <= clock_d;
      has_cur_q <= has_cur_d;
      cur_slot_q <= cur_slot_d;
      found_q   <= found_d;
      has_b_q   <= has_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_due_q  <= cur_due_d;
    best_q     <= best_d;
    best_due_q <= best_due_d;
    slot_q     <= slot_d;
    svc_q      <= svc_d;
    dl_q       <= dl_d;
    ev_a_q     <= ev_a_d;
    id_a_q     <= id_a_d;
    tat_q      <= tat_d;
    wt_q       <= wt_d;
    met_q      <= met_d;
    id_b_q     <= id_b_d;
  end

endmodule

// ===== rtl/deadline_preemptive_scheduler.sv =====
// An arrive beat for a slot beyond the table goes straight to its result; one for a slot in the
// table first reads and checks the slot; a finishing tick scans the whole table before its results.
// No new event beat is taken until the sequencer is back in idle; a finishing tick is held up
// by the table scan through the single read port.
// Reset: control state clears at once, then a clearing pass sweeps every table slot
// while in_stall_o stays high.
module deadline_preemptive_scheduler import dps_pkg::*; #(
  parameter int TASKS = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             cmd_i,
  input  logic [IdW-1:0]   task_req_i,
  input  logic [WorkW-1:0] service_time_i,
  input  logic [WorkW-1:0] deadline_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       event_res_o,
  output logic [IdW-1:0]   task_id_o,
  output logic [TimeW-1:0] now_o,
  output logic [TimeW-1:0] turnaround_o,
  output logic [TimeW-1:0] wait_time_o,
  output logic             deadline_met_o,
  output logic             last_o
);

  localparam int AW = $clog2(TASKS);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  rec_t          wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  rec_t          rd_data;
  logic          res_valid;
  logic          res_ready;
  res_t          res;

  logic          out_valid_q, out_valid_d;
  res_t          out_q;

  dps_table #(.TASKS(TASKS), .AW(AW)) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  dps_seq #(.TASKS(TASKS), .AW(AW)) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .task_req_i     (task_req_i),
    .service_time_i (service_time_i),
    .deadline_i     (deadline_i),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = out_q.ev;
  assign task_id_o      = out_q.id;
  assign now_o          = out_q.now;
  assign turnaround_o   = out_q.tat;
  assign wait_time_o    = out_q.wt;
  assign deadline_met_o = out_q.met;
  assign last_o         = out_q.last;

endmodule

// ===== sim/dps_checker.sv =====
// Checker for the deadline scheduler: predicts every result beat and compares it as it leaves.
module dps_checker import dps_pkg::*; #(
  parameter int TASKS = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic             cmd_i,
  input  logic [IdW-1:0]   task_req_i,
  input  logic [WorkW-1:0] service_time_i,
  input  logic [WorkW-1:0] deadline_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [1:0]       event_res_i,
  input  logic [IdW-1:0]   task_id_i,
  input  logic [TimeW-1:0] now_i,
  input  logic [TimeW-1:0] turnaround_i,
  input  logic [TimeW-1:0] wait_time_i,
  input  logic             deadline_met_i,
  input  logic             last_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic             slot_taken [TASKS];
  logic [TimeW-1:0] entered_at [TASKS];
  logic [WorkW-1:0] work_total [TASKS];
  logic [WorkW-1:0] work_owed  [TASKS];
  logic [WorkW-1:0] due_by     [TASKS];
  logic [TimeW-1:0] sched_time;
  logic [IdW-1:0]   run_slot;
  logic             run_valid;

  res_t due_results [$];
  int   errors = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic res_t make_res(event_e ev, logic [IdW-1:0] id, logic [TimeW-1:0] tat,
                                    logic [TimeW-1:0] wt, logic met);
    res_t r;
    r.ev   = ev;
    r.id   = id;
    r.now  = sched_time;
    r.tat  = tat;
    r.wt   = wt;
    r.met  = met;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic clear_schedule();
    for (int i = 0; i < TASKS; i++) begin
      slot_taken[i] = 1'b0;
      entered_at[i] = '0;
      work_total[i] = '0;
      work_owed[i]  = '0;
      due_by[i]     = '0;
    end
    sched_time = '0;
    run_slot   = '0;
    run_valid  = 1'b0;
    due_results.delete();
  endtask

  task automatic schedule_event(input logic c, input logic [IdW-1:0] s,
                                input logic [WorkW-1:0] svc, input logic [WorkW-1:0] dl);
    res_t             r [2];
    int               n;
    int               best;
    bit               found;
    logic [WorkW-1:0] work;
    logic [TimeW-1:0] tat;
    logic [TimeW-1:0] wt;
    n = 0;
    if (c == CmdArrive) begin
      if (int'(s) >= TASKS || slot_taken[s]) begin
        r[n] = make_res(EvBusy, s, '0, '0, 1'b0);
        n++;
      end else begin
        work = (svc == '0) ? WorkW'(1) : svc;
        slot_taken[s] = 1'b1;
        entered_at[s] = sched_time;
        work_total[s] = work;
        work_owed[s]  = work;
        due_by[s]     = dl;
        r[n] = make_res(EvEntered, s, '0, '0, 1'b0);
        n++;
        if (!run_valid || dl < due_by[run_slot]) begin
          run_valid = 1'b1;
          run_slot  = s;
          r[n] = make_res(EvRunning, s, '0, '0, 1'b0);
          n++;
        end
      end
    end else begin
      sched_time = sched_time + 1;
      if (run_valid && int'(run_slot) < TASKS && slot_taken[run_slot]) begin
        if (work_owed[run_slot] > 0) work_owed[run_slot] = work_owed[run_slot] - 1;
        if (work_owed[run_slot] == 0) begin
          tat = sched_time - entered_at[run_slot];
          wt  = tat - TimeW'(work_total[run_slot]);
          slot_taken[run_slot] = 1'b0;
          run_valid = 1'b0;
          r[n] = make_res(EvFinished, run_slot, tat, wt, tat <= TimeW'(due_by[run_slot]));
          n++;
          best  = 0;
          found = 1'b0;
          for (int i = 0; i < TASKS; i++) begin
            if (slot_taken[i] && (!found || due_by[i] < due_by[best])) begin
              best  = i;
              found = 1'b1;
            end
          end
          if (found) begin
            run_valid = 1'b1;
            run_slot  = IdW'(best);
            r[n] = make_res(EvRunning, IdW'(best), '0, '0, 1'b0);
            n++;
          end
        end
      end else begin
        run_valid = 1'b0;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) r[i].last = 1'b1;
      due_results.push_back(r[i]);
    end
  endtask

  task automatic check_field(input string name, input logic [TimeW-1:0] exp,
                             input logic [TimeW-1:0] act);
    if (act !== exp) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp, act);
      errors++;
    end
  endtask

  initial clear_schedule();

  always @(posedge clk_i) begin : watch
    res_t exp;
    if (!rst_ni) begin
      clear_schedule();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $display("%0t: result beat with none due, expected nothing actual ev %0d id %0d",
                   $time, event_res_i, task_id_i);
          errors++;
        end else begin
          exp = due_results.pop_front();
          check_field("event_res", TimeW'(exp.ev), TimeW'(event_res_i));
          check_field("task_id", TimeW'(exp.id), TimeW'(task_id_i));
          check_field("now", exp.now, now_i);
          check_field("turnaround", exp.tat, turnaround_i);
          check_field("wait_time", exp.wt, wait_time_i);
          check_field("deadline_met", TimeW'(exp.met), TimeW'(deadline_met_i));
          check_field("last", TimeW'(exp.last), TimeW'(last_i));
        end
      end
      if (in_valid_i && !in_stall_i)
        schedule_event(cmd_i, task_req_i, service_time_i, deadline_i);
    end
    fail_count_o <= errors;
    pending_o    <= due_results.size();
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the deadline scheduler: drives event beats, throttles results, gives the verdict.
module tb;
  import dps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Tasks = 128;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid = 1'b0;
  logic             cmd = CmdTick;
  logic [IdW-1:0]   task_req = '0;
  logic [WorkW-1:0] service_time = '0;
  logic [WorkW-1:0] deadline = '0;
  logic             rx_stall = 1'b0;
  logic             rx_hold = 1'b0;
  logic             out_stall;
  logic             calm = 1'b0;
  int               rx_count = 0;
  int               items_sent = 0;

  logic             in_stall;
  logic             out_valid;
  logic [1:0]       event_res;
  logic [IdW-1:0]   task_id;
  logic [TimeW-1:0] now;
  logic [TimeW-1:0] turnaround;
  logic [TimeW-1:0] wait_time;
  logic             deadline_met;
  logic             last;
  int               fail_count;
  int               pending;

  logic [IdW-1:0]   recent [8];
  int               recent_at = 0;

  assign out_stall = rx_stall | rx_hold;

  always #5 clk_i = ~clk_i;

  deadline_preemptive_scheduler #(.TASKS(Tasks)) uut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cmd_i(cmd), .task_req_i(task_req), .service_time_i(service_time),
    .deadline_i(deadline),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .event_res_o(event_res), .task_id_o(task_id), .now_o(now),
    .turnaround_o(turnaround), .wait_time_o(wait_time),
    .deadline_met_o(deadline_met), .last_o(last)
  );

  dps_checker #(.TASKS(Tasks)) u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .cmd_i(cmd), .task_req_i(task_req), .service_time_i(service_time),
    .deadline_i(deadline),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .event_res_i(event_res), .task_id_i(task_id), .now_i(now),
    .turnaround_i(turnaround), .wait_time_i(wait_time),
    .deadline_met_i(deadline_met), .last_i(last),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // after each accepted result beat, stall the result side at random unless calm is set
  always @(posedge clk_i) begin : rx_side
    int w;
    if (!rst_ni) begin
      rx_stall <= 1'b0;
      rx_count <= 0;
    end else if (out_valid && !out_stall) begin
      w = calm ? 0 : $urandom_range(0, 12);
      rx_count <= w;
      rx_stall <= (w != 0);
    end else if (rx_count > 0) begin
      rx_count <= rx_count - 1;
      rx_stall <= (rx_count > 1);
    end
  end

  // back up the result side long enough to fill the block
  initial begin
    wait (items_sent >= 300);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (600) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic offer_event(input logic c, input logic [IdW-1:0] s,
                             input logic [WorkW-1:0] svc, input logic [WorkW-1:0] dl);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    cmd          <= c;
    task_req     <= s;
    service_time <= svc;
    deadline     <= dl;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic arrive(input logic [IdW-1:0] s, input logic [WorkW-1:0] svc,
                        input logic [WorkW-1:0] dl);
    recent[recent_at % 8] = s;
    recent_at++;
    offer_event(CmdArrive, s, svc, dl);
  endtask

  task automatic tick();
    offer_event(CmdTick, IdW'($urandom), WorkW'($urandom), WorkW'($urandom));
  endtask

  task automatic random_event();
    int               p;
    logic [IdW-1:0]   s;
    logic [WorkW-1:0] svc;
    logic [WorkW-1:0] dl;
    bit               dl_set;
    if ($urandom_range(0, 99) < 68) begin
      tick();
    end else begin
      dl_set = 1'b0;
      if (recent_at > 0 && $urandom_range(0, 6) == 0)
        s = recent[$urandom_range(0, 7)];
      else
        s = IdW'($urandom_range(0, 127));
      p = $urandom_range(0, 99);
      if (p < 3) begin
        svc    = WorkW'($urandom);
        dl     = {8'hFF, 8'($urandom)};
        dl_set = 1'b1;
      end else if (p < 8) begin
        svc = '0;
      end else begin
        svc = WorkW'($urandom_range(1, 12));
      end
      if (!dl_set) begin
        p = $urandom_range(0, 9);
        if (p < 6)      dl = WorkW'($urandom_range(0, 40));
        else if (p < 8) dl = WorkW'($urandom);
        else if (p < 9) dl = '1;
        else            dl = '0;
      end
      arrive(s, svc, dl);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    tick();
    arrive(7'd0, 16'd1, 16'hFFFF);
    arrive(7'd127, 16'd0, 16'hFFFF);
    arrive(7'd0, 16'd5, 16'd0);
    arrive(7'd127, 16'd9, 16'd9);
    arrive(7'd42, 16'd3, 16'd0);
    repeat (4) tick();
    arrive(7'd1, 16'd2, 16'hFFFF);
    repeat (4) tick();
    arrive(7'd85, 16'hFFFF, 16'hFFFF);
    arrive(7'd21, 16'd4, 16'd20);
    repeat (4) tick();

    for (int k = 0; k < 1380; k++) begin
      calm <= (k >= 600 && k < 760);
      random_event();
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    repeat (Tasks + 16) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
